[hdl/ets_pkg.sv]
// ets_pkg: token kinds, scan phases, result structs and character class functions
// for the expression token scanner; no dependencies
`timescale 1ns / 1ps

package ets_pkg;

    typedef enum logic [3:0] {
        K_WHITE   = 4'd0,
        K_LPAREN  = 4'd1,
        K_RPAREN  = 4'd2,
        K_COMMA   = 4'd3,
        K_MINUS   = 4'd4,
        K_PLUS    = 4'd5,
        K_STAR    = 4'd6,
        K_SLASH   = 4'd7,
        K_CARET   = 4'd8,
        K_DECIMAL = 4'd9,
        K_INTEGER = 4'd10,
        K_IDENT   = 4'd11,
        K_ERROR   = 4'd12,
        K_END     = 4'd13
    } kind_t;

    typedef enum logic [3:0] {
        PH_IDLE    = 4'd0,
        PH_WHITE   = 4'd1,
        PH_IDENT   = 4'd2,
        PH_INT     = 4'd3,
        PH_INTDOT  = 4'd4,
        PH_DOT     = 4'd5,
        PH_FRAC    = 4'd6,
        PH_EXP     = 4'd7,
        PH_EXPSIGN = 4'd8,
        PH_EXPDIG  = 4'd9
    } phase_t;

    localparam int LenW       = 10;
    localparam int LenMax     = 1023;
    localparam int MaxResults = 3;
    localparam int QueueDepth = 8;
    localparam int QueuePtrW  = 3;
    localparam int QueueCntW  = 4;

    localparam logic [7:0] ChrDot   = 8'h2E;
    localparam logic [7:0] ChrUnder = 8'h5F;
    localparam logic [7:0] ChrCaret = 8'h5E;
    localparam logic [7:0] ChrComma = 8'h2C;
    localparam logic [7:0] ChrLowE  = 8'h65;
    localparam logic [7:0] ChrUpE   = 8'h45;
    localparam logic [7:0] ChrPlus  = 8'h2B;
    localparam logic [7:0] ChrMinus = 8'h2D;
    localparam logic [7:0] ChrStar  = 8'h2A;
    localparam logic [7:0] ChrSlash = 8'h2F;
    localparam logic [7:0] ChrLpar  = 8'h28;
    localparam logic [7:0] ChrRpar  = 8'h29;
    localparam logic [7:0] ChrSpace = 8'h20;
    localparam logic [7:0] ChrTab   = 8'h09;
    localparam logic [7:0] ChrNl    = 8'h0A;

    typedef struct packed {
        kind_t            kind;
        logic [LenW-1:0]  length;
        logic             last;
    } token_t;

    typedef struct packed {
        logic [1:0]   count;
        token_t [2:0] tok;
    } scan_result_t;

    function automatic logic digit_code(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic letter_code(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    function automatic logic blank_code(input logic [7:0] c);
        return (c == ChrSpace) || (c == ChrTab) || (c == ChrNl);
    endfunction

    function automatic logic is_exp(input logic [7:0] c);
        return (c == ChrLowE) || (c == ChrUpE);
    endfunction

    function automatic phase_t extend_phase(input phase_t ph, input logic [7:0] c);
        phase_t nx;
        nx = PH_IDLE;
        unique case (ph)
            PH_WHITE:   nx = blank_code(c) ? PH_WHITE : PH_IDLE;
            PH_IDENT:
                nx = (letter_code(c) || digit_code(c) || c == ChrUnder)
                     ? PH_IDENT : PH_IDLE;
            PH_INT:
            begin
                if (digit_code(c))    nx = PH_INT;
                else if (c == ChrDot) nx = PH_INTDOT;
                else if (is_exp(c))   nx = PH_EXP;
            end
            PH_INTDOT, PH_FRAC:
            begin
                if (digit_code(c))  nx = PH_FRAC;
                else if (is_exp(c)) nx = PH_EXP;
            end
            PH_DOT:     nx = digit_code(c) ? PH_FRAC : PH_IDLE;
            PH_EXP:
            begin
                if (c == ChrPlus || c == ChrMinus) nx = PH_EXPSIGN;
                else if (digit_code(c))            nx = PH_EXPDIG;
            end
            PH_EXPSIGN, PH_EXPDIG: nx = digit_code(c) ? PH_EXPDIG : PH_IDLE;
            default:    nx = PH_IDLE;
        endcase
        return nx;
    endfunction

    function automatic phase_t start_phase(input logic [7:0] c);
        phase_t st;
        priority if (blank_code(c)) st = PH_WHITE;
        else if (letter_code(c))    st = PH_IDENT;
        else if (digit_code(c))     st = PH_INT;
        else if (c == ChrDot)       st = PH_DOT;
        else                        st = PH_IDLE;
        return st;
    endfunction

    function automatic kind_t single_kind(input logic [7:0] c);
        kind_t k;
        unique case (c)
            ChrLpar:  k = K_LPAREN;
            ChrRpar:  k = K_RPAREN;
            ChrComma: k = K_COMMA;
            ChrMinus: k = K_MINUS;
            ChrPlus:  k = K_PLUS;
            ChrStar:  k = K_STAR;
            ChrSlash: k = K_SLASH;
            ChrCaret: k = K_CARET;
            default:  k = K_ERROR;
        endcase
        return k;
    endfunction

    function automatic kind_t close_kind(input phase_t ph);
        kind_t k;
        unique case (ph)
            PH_WHITE:                  k = K_WHITE;
            PH_IDENT:                  k = K_IDENT;
            PH_INT:                    k = K_INTEGER;
            PH_INTDOT, PH_FRAC, PH_EXPDIG: k = K_DECIMAL;
            default:                   k = K_ERROR;
        endcase
        return k;
    endfunction

endpackage

[hdl/ets_channels.sv]
// ets_char_if and ets_token_if: valid/ready channels of the expression token scanner
// no dependencies
`timescale 1ns / 1ps

interface ets_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       end_of_text;

    modport source (output valid, output char_code, output end_of_text, input ready);
    modport sink (input valid, input char_code, input end_of_text, output ready);
endinterface

interface ets_token_if;
    logic       valid;
    logic       ready;
    logic [3:0] token_kind;
    logic [9:0] token_length;
    logic       last_of_run;

    modport source (output valid, output token_kind, output token_length,
                    output last_of_run, input ready);
    modport sink (input valid, input token_kind, input token_length,
                  input last_of_run, output ready);
endinterface

[hdl/ets_scan_core.sv]
// ets_scan_core: scanner phase and open length registers, with the single-pass
// token logic for one character; depends on ets_pkg
`timescale 1ns / 1ps

module ets_scan_core
    import ets_pkg::*;
#(
    parameter logic [LenW-1:0] LEN_CAP = 10'd1023
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         step,
    input  logic [7:0]   char_code,
    input  logic         end_of_text,
    output scan_result_t result
);

    phase_t          phase_reg;
    phase_t          phase_next;
    logic [LenW-1:0] length_reg;
    logic [LenW-1:0] length_next;

    always_comb
    begin
        phase_t          ph;
        phase_t          nx;
        phase_t          st;
        logic [LenW-1:0] len;
        logic [1:0]      n;
        logic            taken;
        scan_result_t    r;

        r     = '0;
        n     = 2'd0;
        taken = 1'b0;
        nx    = PH_IDLE;
        st    = PH_IDLE;
        len   = length_reg;
        unique case (phase_reg)
            PH_WHITE, PH_IDENT, PH_INT, PH_INTDOT, PH_DOT, PH_FRAC,
            PH_EXP, PH_EXPSIGN, PH_EXPDIG: ph = phase_reg;
            default:                       ph = PH_IDLE;
        endcase

        if (ph != PH_IDLE)
        begin
            nx = extend_phase(ph, char_code);
            if (nx != PH_IDLE)
            begin
                ph    = nx;
                len   = (len < LEN_CAP) ? len + 10'd1 : len;
                taken = 1'b1;
            end
            else
            begin
                r.tok[n].kind   = close_kind(ph);
                r.tok[n].length = len;
                n               = n + 2'd1;
                ph              = PH_IDLE;
                len             = '0;
            end
        end

        if (!taken)
        begin
            st = start_phase(char_code);
            if (st != PH_IDLE)
            begin
                ph  = st;
                len = 10'd1;
            end
            else
            begin
                r.tok[n].kind   = single_kind(char_code);
                r.tok[n].length = 10'd1;
                n               = n + 2'd1;
            end
        end

        if (end_of_text)
        begin
            if (ph != PH_IDLE)
            begin
                r.tok[n].kind   = close_kind(ph);
                r.tok[n].length = len;
                n               = n + 2'd1;
            end
            r.tok[n].kind   = K_END;
            r.tok[n].length = '0;
            n               = n + 2'd1;
            ph              = PH_IDLE;
            len             = '0;
        end

        if (n != 2'd0)
        begin
            r.tok[n - 2'd1].last = 1'b1;
        end
        r.count     = n;
        result      = r;
        phase_next  = ph;
        length_next = len;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            length_reg <= '0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            length_reg <= length_next;
        end
    end

    a_eot_idle: assert property (@(posedge clk) disable iff (!rst_n)
        step && end_of_text |=> phase_reg == PH_IDLE && length_reg == '0)
        else $error("phase not idle after end of text");

    a_eot_end_token: assert property (@(posedge clk) disable iff (!rst_n)
        step && end_of_text |-> result.count != 2'd0
            && result.tok[result.count - 2'd1].kind == K_END)
        else $error("end of text without end token");

    a_len_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != PH_IDLE) == (length_reg != '0))
        else $error("open length disagrees with phase");

endmodule

[hdl/ets_token_queue.sv]
// ets_token_queue: result queue that takes up to three tokens per cycle and
// delivers one per transaction; depends on ets_pkg and ets_channels
`timescale 1ns / 1ps

module ets_token_queue
    import ets_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  scan_result_t push,
    output logic         room,
    ets_token_if.source  token_out
);

    token_t                entry_reg [QueueDepth];
    logic [QueuePtrW-1:0]  wr_ptr_reg;
    logic [QueuePtrW-1:0]  wr_ptr_next;
    logic [QueuePtrW-1:0]  rd_ptr_reg;
    logic [QueuePtrW-1:0]  rd_ptr_next;
    logic [QueueCntW-1:0]  count_reg;
    logic [QueueCntW-1:0]  count_next;
    logic [QueueCntW-1:0]  free_slots;
    logic                  pop;

    assign free_slots = QueueCntW'(QueueDepth) - count_reg;
    assign room       = free_slots >= QueueCntW'(MaxResults);
    assign pop        = token_out.valid && token_out.ready;

    assign token_out.valid        = count_reg != '0;
    assign token_out.token_kind   = entry_reg[rd_ptr_reg].kind;
    assign token_out.token_length = entry_reg[rd_ptr_reg].length;
    assign token_out.last_of_run  = entry_reg[rd_ptr_reg].last;

    assign wr_ptr_next = wr_ptr_reg + QueuePtrW'(push.count);
    assign rd_ptr_next = rd_ptr_reg + QueuePtrW'(pop);
    assign count_next  = count_reg + QueueCntW'(push.count) - QueueCntW'(pop);

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MaxResults; i++)
        begin
            if (2'(i) < push.count)
            begin
                entry_reg[wr_ptr_reg + QueuePtrW'(i)] <= push.tok[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_push_fits: assert property (@(posedge clk) disable iff (!rst_n)
        QueueCntW'(push.count) <= free_slots + QueueCntW'(pop))
        else $error("token queue overrun");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QueueCntW'(QueueDepth))
        else $error("token queue count out of range");

    a_pop_only: assert property (@(posedge clk) disable iff (!rst_n)
        pop && push.count == 2'd0 |=> count_reg == $past(count_reg) - 4'd1)
        else $error("token queue count did not drop on pop");

endmodule

[hdl/expression_token_scanner_unit.sv]
// expression_token_scanner_unit: streaming lexer for arithmetic expression text
// depends on ets_pkg, ets_channels, ets_scan_core and ets_token_queue
//
// char_in carries one ASCII character per transaction with an end_of_text flag.
// token_out carries the closed tokens: kind, length and a last_of_run flag on the
// final token caused by one character. A character gives zero to three tokens.
// The character lands in an input register; once the queue has room the scan logic
// classifies it against the held phase and open length and writes its tokens
// into an eight-entry queue. A token is offered from the queue after passing
// through the input register and the queue register, and leaves on a handshake.
// One character is taken every cycle while the queue has room for
// three more tokens; a character that gives three tokens still delivers them
// one per transaction, so a long run of those paces input to the output rate.
// When token_out stalls the queue fills and char_in.ready drops once fewer than
// three entries are free; nothing is lost. Reset empties the queue and input
// register and returns the scanner to idle with no token open. After end of
// text the scanner is idle and the next character starts a new text.
`timescale 1ns / 1ps

module expression_token_scanner_unit
    import ets_pkg::*;
#(
    parameter int MAX_TOKEN_LEN = 1023
)
(
    input  logic        clk,
    input  logic        rst_n,
    ets_char_if.sink    char_in,
    ets_token_if.source token_out
);

    localparam logic [LenW-1:0] LenCap =
        LenW'((MAX_TOKEN_LEN < LenMax) ? MAX_TOKEN_LEN : LenMax);

    logic         in_valid_reg;
    logic [7:0]   char_reg;
    logic         eot_reg;
    logic         room;
    logic         step;
    logic         take;
    scan_result_t scan_result;
    scan_result_t push;

    assign step          = in_valid_reg && room;
    assign char_in.ready = !in_valid_reg || step;
    assign take          = char_in.valid && char_in.ready;

    always_comb
    begin
        push = scan_result;
        if (!step)
        begin
            push.count = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (step)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            char_reg <= char_in.char_code;
            eot_reg  <= char_in.end_of_text;
        end
    end

    ets_scan_core #(
        .LEN_CAP (LenCap)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .char_code   (char_reg),
        .end_of_text (eot_reg),
        .result      (scan_result)
    );

    ets_token_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .token_out (token_out)
    );

endmodule
